@@ src/wlss_pkg.sv @@
// ----------------------------------------------------------------------------
// wlss_pkg
// Shared widths, register indexes and reset values of the windowed
// least-squares slope block.
// ----------------------------------------------------------------------------
package wlss_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int ALT_W      = 24;
  localparam int TIME_W     = 32;
  localparam int WIN_W      = 16;
  localparam int LIM_W      = 7;
  localparam int AGE_W      = 16;
  localparam int SPEED_W    = 24;
  localparam int Q_W        = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;

  localparam logic [WIN_W-1:0] WINDOW_RST = 16'd1000;
  localparam int               LIMIT_RST  = 64;

  localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 24'h7FFFFF;
  localparam logic [SPEED_W-1:0] SPEED_NEG_MAG = 24'h800000;

endpackage

@@ src/windowed_least_squares_slope.sv @@
// ----------------------------------------------------------------------------
// windowed_least_squares_slope
// Vertical speed from a least-squares fit over a time window of altitude
// samples held in a ring memory.
// Processing: a ring walk, one memory read a cycle until the walk passes the
// window or the ring ends, then four shift-add products at one multiplier
// bit a cycle, a load step and a 24-step restoring division. Fewer than three
// samples, a non-positive denominator or a saturated quotient end it early.
// One item is in work at a time; the next is taken once the result is queued.
// Reset restores window_ms 1000 and sample_limit 64 (capped at CAPACITY) and empties the ring.
// ----------------------------------------------------------------------------
module windowed_least_squares_slope
  import wlss_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ALT_W-1:0]   altitude_cm,
  input  logic [TIME_W-1:0]         time_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] speed_cm_s,
  output logic                      ready_res,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int SXW   = AGE_W + CW;
  localparam int SXXW  = 2 * AGE_W + CW;
  localparam int SYW   = ALT_W + CW;
  localparam int AYW   = AGE_W + 1 + ALT_W;
  localparam int SAYW  = AYW + CW;
  localparam int PW    = AGE_W + 1 + ALT_W + 2 * CW + 1;
  localparam int DW    = PW + 10;
  localparam int EW    = PW + Q_W;
  localparam int QCW   = $clog2(Q_W);
  localparam logic [CW-1:0] LIM_RST_EFF =
    CW'((LIMIT_RST > CAPACITY) ? CAPACITY : LIMIT_RST);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WALK   = 7'b0000010,
    ST_MLOAD  = 7'b0000100,
    ST_MSTEP  = 7'b0001000,
    ST_DLOAD  = 7'b0010000,
    ST_DSTEP  = 7'b0100000,
    ST_FINISH = 7'b1000000
  } state_t;

  state_t state;

  logic [WIN_W-1:0]  window;
  logic [CW-1:0]     lim;
  logic [AW-1:0]     wp;
  logic [CW-1:0]     fc;
  logic [SPEED_W-1:0] last_speed;
  logic              ready_flag;

  logic [CW-1:0]     rem;
  logic [AW-1:0]     rd_addr;
  logic [TIME_W-1:0] now_r;
  logic              stopped;
  logic              rd_v;
  logic              a_valid;
  logic [AGE_W-1:0]  a_age;
  logic signed [ALT_W-1:0] a_y;
  logic              a_in;

  logic [CW-1:0]            n;
  logic [SXW-1:0]           sxm;
  logic [SXXW-1:0]          sxx;
  logic signed [SYW-1:0]    sy;
  logic signed [SAYW-1:0]   say;
  logic [AGE_W-1:0]         last_age;

  logic [1:0]               term;
  logic signed [PW-1:0]     m_a;
  logic [SXW-1:0]           m_b;
  logic signed [PW-1:0]     prod;
  logic signed [PW-1:0]     den;
  logic signed [PW-1:0]     num;

  logic                     hold;
  logic                     neg;
  logic [DW-1:0]            rem_d;
  logic [EW-1:0]            dsh;
  logic [Q_W-1:0]           q;
  logic [QCW-1:0]           qcnt;

  logic                     accept;
  logic                     rd_en;
  logic [ALT_W-1:0]         alt_rdata;
  logic [TIME_W-1:0]        time_rdata;
  logic [TIME_W-1:0]        age_full;
  logic [AW-1:0]            wp_inc;
  logic [AW-1:0]            wp_prev;
  logic [AW-1:0]            rd_prev;
  logic [CW-1:0]            fc_next;
  logic [CW-1:0]            lim_wr;
  logic [2*AGE_W-1:0]       age_sq;
  logic signed [AYW-1:0]    age_y;
  logic [PW-1:0]            mag;
  logic [DW-1:0]            dvd;
  logic [EW-1:0]            trial_sat;
  logic                     ge;
  logic [SPEED_W-1:0]       lim_v;
  logic [SPEED_W-1:0]       res_mag;
  logic [SPEED_W-1:0]       speed_val;
  logic [AGE_W+4:0]         span10;
  logic [AGE_W+4:0]         win8;
  logic                     span_ok;

  assign in_ready   = (state == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign speed_cm_s = last_speed;
  assign ready_res  = ready_flag;

  wlss_ram #(.WIDTH(ALT_W), .DEPTH(CAPACITY), .ADDR_W(AW)) u_alt_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (altitude_cm),
    .raddr (rd_addr),
    .rdata (alt_rdata)
  );

  wlss_ram #(.WIDTH(TIME_W), .DEPTH(CAPACITY), .ADDR_W(AW)) u_time_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wp),
    .wdata (time_ms),
    .raddr (rd_addr),
    .rdata (time_rdata)
  );

  always_comb begin
    wp_inc  = (CW'(wp) + 1'b1 == lim) ? '0 : AW'(wp + 1'b1);
    wp_prev = (wp == '0) ? AW'(lim - 1'b1) : AW'(wp - 1'b1);
    rd_prev = (rd_addr == '0) ? AW'(lim - 1'b1) : AW'(rd_addr - 1'b1);
    fc_next = (fc < lim) ? CW'(fc + 1'b1) : fc;
    if (cfg_data[LIM_W-1:0] == '0) begin
      lim_wr = CW'(1);
    end else if (int'(cfg_data[LIM_W-1:0]) > CAPACITY) begin
      lim_wr = CW'(CAPACITY);
    end else begin
      lim_wr = CW'(cfg_data[LIM_W-1:0]);
    end
    rd_en    = (state == ST_WALK) && (rem != '0) && !stopped;
    age_full = now_r - time_rdata;
    age_sq   = a_age * a_age;
    age_y    = $signed({1'b0, a_age}) * a_y;
    mag      = num[PW-1] ? PW'(-num) : PW'(num);
    dvd      = ({mag, 10'b0}) - DW'({mag, 4'b0}) - DW'({mag, 3'b0});
    trial_sat = EW'(den) << Q_W;
    ge       = (EW'(rem_d) >= dsh);
    lim_v    = neg ? SPEED_NEG_MAG : SPEED_POS_MAX;
    res_mag  = (q > lim_v) ? lim_v : q;
    speed_val = neg ? SPEED_W'(-res_mag) : res_mag;
    span10   = (AGE_W+5)'({last_age, 3'b0}) + (AGE_W+5)'({last_age, 1'b0});
    win8     = (AGE_W+5)'({window, 3'b0});
    span_ok  = (span10 >= win8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      window     <= WINDOW_RST;
      lim        <= LIM_RST_EFF;
      wp         <= '0;
      fc         <= '0;
      last_speed <= '0;
      ready_flag <= 1'b0;
      out_valid  <= 1'b0;
      rd_v       <= 1'b0;
      a_valid    <= 1'b0;
      stopped    <= 1'b0;
    end else begin
      rd_v    <= rd_en;
      a_valid <= rd_v;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW: begin
            window     <= cfg_data[WIN_W-1:0];
            wp         <= '0;
            fc         <= '0;
            last_speed <= '0;
            ready_flag <= 1'b0;
          end
          REG_LIMIT: begin
            lim        <= lim_wr;
            wp         <= '0;
            fc         <= '0;
            last_speed <= '0;
            ready_flag <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            wp       <= wp_inc;
            fc       <= fc_next;
            rem      <= CW'(fc_next - 1'b1);
            rd_addr  <= wp_prev;
            now_r    <= time_ms;
            n        <= CW'(1);
            sxm      <= '0;
            sxx      <= '0;
            sy       <= SYW'(altitude_cm);
            say      <= '0;
            last_age <= '0;
            stopped  <= 1'b0;
            state    <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (rd_en) begin
            rem     <= CW'(rem - 1'b1);
            rd_addr <= rd_prev;
          end
          if (a_valid && !stopped) begin
            if (a_in) begin
              n        <= CW'(n + 1'b1);
              sxm      <= SXW'(sxm + SXW'(a_age));
              sxx      <= SXXW'(sxx + SXXW'(age_sq));
              sy       <= SYW'(sy + SYW'(a_y));
              say      <= SAYW'(say + SAYW'(age_y));
              last_age <= a_age;
            end else begin
              stopped <= 1'b1;
            end
          end
          if ((rem == '0 || stopped) && !rd_v && !a_valid) begin
            term <= 2'd0;
            if (n < CW'(3)) begin
              hold  <= 1'b1;
              state <= ST_FINISH;
            end else begin
              state <= ST_MLOAD;
            end
          end
        end
        ST_MLOAD: begin
          prod <= '0;
          case (term)
            2'd0: begin
              m_a <= PW'($signed({1'b0, sxx}));
              m_b <= SXW'(n);
            end
            2'd1: begin
              m_a <= PW'($signed({1'b0, sxm}));
              m_b <= sxm;
            end
            2'd2: begin
              m_a <= PW'(sy);
              m_b <= sxm;
            end
            default: begin
              m_a <= PW'(say);
              m_b <= SXW'(n);
            end
          endcase
          state <= ST_MSTEP;
        end
        ST_MSTEP: begin
          if (m_b == '0) begin
            case (term)
              2'd0:    den <= prod;
              2'd1:    den <= den - prod;
              2'd2:    num <= prod;
              default: num <= num - prod;
            endcase
            term  <= term + 2'd1;
            state <= (term == 2'd3) ? ST_DLOAD : ST_MLOAD;
          end else begin
            if (m_b[0]) begin
              prod <= prod + m_a;
            end
            m_a <= m_a <<< 1;
            m_b <= m_b >> 1;
          end
        end
        ST_DLOAD: begin
          if (den[PW-1] || den == '0) begin
            hold  <= 1'b1;
            state <= ST_FINISH;
          end else begin
            hold  <= 1'b0;
            neg   <= num[PW-1];
            rem_d <= dvd;
            dsh   <= EW'(den) << (Q_W - 1);
            qcnt  <= QCW'(Q_W - 1);
            if (EW'(dvd) >= trial_sat) begin
              q     <= '1;
              state <= ST_FINISH;
            end else begin
              q     <= '0;
              state <= ST_DSTEP;
            end
          end
        end
        ST_DSTEP: begin
          if (ge) begin
            rem_d <= DW'(EW'(rem_d) - dsh);
          end
          q   <= {q[Q_W-2:0], ge};
          dsh <= dsh >> 1;
          if (qcnt == '0) begin
            state <= ST_FINISH;
          end else begin
            qcnt <= qcnt - 1'b1;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (hold) begin
              ready_flag <= 1'b0;
            end else begin
              last_speed <= speed_val;
              ready_flag <= span_ok;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v) begin
      a_age <= age_full[AGE_W-1:0];
      a_y   <= alt_rdata;
      a_in  <= (age_full <= TIME_W'(window));
    end
  end

  a_ring_bounds: assert property (@(posedge clk) disable iff (rst)
    (fc <= lim) && (CW'(wp) < lim))
    else $error("ring pointer or fill count beyond the sample limit");

  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_index == REG_WINDOW || cfg_index == REG_LIMIT) && !accept
    |=> (fc == '0) && (wp == '0) && (last_speed == '0) && !ready_flag)
    else $error("configuration write did not clear the track");

  a_accept_walk: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_WALK) && (n == CW'(1)) && (fc != '0))
    else $error("accepted sample did not start a ring walk");

  a_div_positive: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DSTEP) |-> (!den[PW-1] && den != '0 && dsh != '0))
    else $error("division running with a non-positive denominator");

endmodule

@@ src/wlss_ram.sv @@
// ----------------------------------------------------------------------------
// wlss_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module wlss_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
